// ----- rtl/core/sla_pkg.sv -----
`timescale 1ns / 1ps

package sla_pkg;

    localparam int CFG_W          = 13;
    localparam int BYTE_W         = 8;
    localparam int LIMIT_MAX_DEF  = 4096;
    localparam logic [CFG_W-1:0] MAX_LINE_RESET = 13'd2048;

    localparam int MARK_LEN   = 15;
    localparam int MARK_IDX_W = $clog2(MARK_LEN + 1);

    localparam logic [BYTE_W-1:0] CHAR_LF    = 8'h0A;
    localparam logic [BYTE_W-1:0] CHAR_CR    = 8'h0D;
    localparam logic [BYTE_W-1:0] CHAR_SPACE = 8'h20;
    localparam logic [BYTE_W-1:0] CHAR_DEL   = 8'h7F;

    localparam logic ACT_BYTE  = 1'b0;
    localparam logic ACT_FLUSH = 1'b1;

    typedef struct packed {
        logic              action;
        logic [BYTE_W-1:0] byte_value;
    } t_item;

    // " ...[truncated]"
    function automatic logic [BYTE_W-1:0] mark_char(input logic [MARK_IDX_W-1:0] idx);
        logic [BYTE_W-1:0] ch;
        case (idx)
            4'd0:    ch = 8'h20;
            4'd1:    ch = 8'h2E;
            4'd2:    ch = 8'h2E;
            4'd3:    ch = 8'h2E;
            4'd4:    ch = 8'h5B;
            4'd5:    ch = 8'h74;
            4'd6:    ch = 8'h72;
            4'd7:    ch = 8'h75;
            4'd8:    ch = 8'h6E;
            4'd9:    ch = 8'h63;
            4'd10:   ch = 8'h61;
            4'd11:   ch = 8'h74;
            4'd12:   ch = 8'h65;
            4'd13:   ch = 8'h64;
            4'd14:   ch = 8'h5D;
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

endpackage

// ----- rtl/core/sla_in_stage.sv -----
`timescale 1ns / 1ps

module sla_in_stage
    import sla_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    output logic  o_ready,
    input  t_item i_item,
    output logic  o_valid,
    input  logic  i_take,
    output t_item o_item
);

    logic  r_valid;
    t_item r_item;

    // reload whenever the held beat is empty or leaves this cycle
    assign o_ready = !r_valid || i_take;
    assign o_valid = r_valid;
    assign o_item  = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_item <= i_item;
        end
    end

endmodule

// ----- rtl/core/sla_framer.sv -----
`timescale 1ns / 1ps

module sla_framer
    import sla_pkg::*;
#(
    parameter int LINE_LIMIT_MAX = LIMIT_MAX_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_valid,
    input  logic [CFG_W-1:0]  i_cfg_data,
    input  logic              i_valid,
    input  t_item             i_item,
    output logic              o_take,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [BYTE_W-1:0] o_char,
    output logic              o_eol,
    output logic              o_last
);

    localparam int LEN_W = $clog2(LINE_LIMIT_MAX + 1);
    localparam int CMP_W = ((LEN_W > CFG_W) ? LEN_W : CFG_W) + 1;

    logic [CFG_W-1:0]      r_cfg;
    logic [LEN_W-1:0]      r_len,   n_len;
    logic                  r_cr,    n_cr;
    logic                  r_swal,  n_swal;
    logic                  r_mark;
    logic [MARK_IDX_W-1:0] r_midx;
    logic                  r_valid;
    logic [BYTE_W-1:0]     r_char;
    logic                  r_eol;
    logic                  r_last;

    logic              emit;
    logic [BYTE_W-1:0] e_char;
    logic              e_eol;
    logic              trunc;
    logic [CMP_W-1:0]  eff_lim;
    logic [CMP_W-1:0]  len_inc;
    logic              out_free;

    assign out_free = !r_valid || i_ready;
    assign o_take   = i_valid && !r_mark && out_free;

    always_comb begin
        if (r_cfg == '0) begin
            eff_lim = CMP_W'(1);
        end else if (CMP_W'(r_cfg) > CMP_W'(LINE_LIMIT_MAX)) begin
            eff_lim = CMP_W'(LINE_LIMIT_MAX);
        end else begin
            eff_lim = CMP_W'(r_cfg);
        end
        len_inc = CMP_W'(r_len) + CMP_W'(1);
    end

    always_comb begin
        n_len  = r_len;
        n_cr   = r_cr;
        n_swal = r_swal;
        emit   = 1'b0;
        e_char = '0;
        e_eol  = 1'b0;
        trunc  = 1'b0;
        if (i_item.action == ACT_FLUSH) begin
            if (!r_swal && r_len != '0) begin
                emit  = 1'b1;
                e_eol = 1'b1;
            end
            n_len  = '0;
            n_cr   = 1'b0;
            n_swal = 1'b0;
        end else if (i_item.byte_value == CHAR_LF && r_cr) begin
            n_cr = 1'b0;
        end else if (i_item.byte_value == CHAR_LF || i_item.byte_value == CHAR_CR) begin
            n_cr = (i_item.byte_value == CHAR_CR);
            // the marker already closed a swallowed line
            if (r_swal) begin
                n_swal = 1'b0;
            end else if (r_len != '0) begin
                emit  = 1'b1;
                e_eol = 1'b1;
            end
            n_len = '0;
        end else begin
            n_cr = 1'b0;
            if (!r_swal && i_item.byte_value >= CHAR_SPACE
                    && i_item.byte_value != CHAR_DEL) begin
                emit   = 1'b1;
                e_char = i_item.byte_value;
                if (len_inc >= eff_lim) begin
                    trunc  = 1'b1;
                    n_len  = '0;
                    n_swal = 1'b1;
                end else begin
                    n_len = LEN_W'(len_inc);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= MAX_LINE_RESET;
        end else if (i_cfg_valid) begin
            r_cfg <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len  <= '0;
            r_cr   <= 1'b0;
            r_swal <= 1'b0;
        end else if (o_take) begin
            r_len  <= n_len;
            r_cr   <= n_cr;
            r_swal <= n_swal;
        end
    end

    // result register and marker sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_mark  <= 1'b0;
            r_midx  <= '0;
        end else if (r_mark) begin
            if (i_ready) begin
                if (r_midx == MARK_IDX_W'(MARK_LEN)) begin
                    r_mark <= 1'b0;
                    r_midx <= '0;
                end else begin
                    r_midx <= r_midx + MARK_IDX_W'(1);
                end
            end
        end else if (o_take) begin
            r_valid <= emit;
            if (trunc) begin
                r_mark <= 1'b1;
                r_midx <= '0;
            end
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_mark) begin
            if (i_ready) begin
                r_char <= mark_char(r_midx);
                r_eol  <= (r_midx == MARK_IDX_W'(MARK_LEN));
                r_last <= (r_midx == MARK_IDX_W'(MARK_LEN));
            end
        end else if (o_take && emit) begin
            r_char <= e_char;
            r_eol  <= e_eol;
            r_last <= !trunc;
        end
    end

    assign o_valid = r_valid;
    assign o_char  = r_char;
    assign o_eol   = r_eol;
    assign o_last  = r_last;

endmodule

// ----- rtl/core/serial_line_assembler_core.sv -----
`timescale 1ns / 1ps
// serial line assembler: splits a received byte stream into lines
// slave stream: one beat per received byte (tuser 0) or flush (tuser 1)
// master stream: one beat per line character, tuser 1 marks end of line,
// tlast flags the final beat that one input beat causes
// cr, lf and crlf end a line; control bytes and del are dropped
// a line that reaches the limit gets " ...[truncated]" and an end of line,
// and the rest of it is swallowed up to the next terminator
// config channel: one write sets the line length limit (0 acts as 1, values above LINE_LIMIT_MAX are clamped)
// path: an input beat is held in the input register, then its first result beat in the result register
// throughput: one input beat per cycle while the master side is ready; after a truncating
// byte the input holds while the marker sequencer sends its beats
// reset: line state cleared, limit back to 2048, no beat pending
// a stalled master side holds the result register; the input register
// keeps one more beat, then the slave side stalls too
module serial_line_assembler_core
    import sla_pkg::*;
#(
    parameter int LINE_LIMIT_MAX = LIMIT_MAX_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [CFG_W-1:0]  i_cfg_data,      // [12:0] max_line_length
    input  logic              i_s_axis_tvalid,
    output logic              o_s_axis_tready,
    input  logic [BYTE_W-1:0] i_s_axis_tdata,  // [7:0] byte_value
    input  logic              i_s_axis_tuser,  // [0] action
    output logic              o_m_axis_tvalid,
    input  logic              i_m_axis_tready,
    output logic [BYTE_W-1:0] o_m_axis_tdata,  // [7:0] char_value
    output logic              o_m_axis_tuser,  // [0] end_of_line
    output logic              o_m_axis_tlast
);

    t_item in_item;
    t_item st_item;
    logic  st_valid;
    logic  take;

    assign o_cfg_ready        = 1'b1;
    assign in_item.action     = i_s_axis_tuser;
    assign in_item.byte_value = i_s_axis_tdata;

    sla_in_stage u_in_stage (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_axis_tvalid),
        .o_ready (o_s_axis_tready),
        .i_item  (in_item),
        .o_valid (st_valid),
        .i_take  (take),
        .o_item  (st_item)
    );

    sla_framer #(
        .LINE_LIMIT_MAX (LINE_LIMIT_MAX)
    ) u_framer (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .i_valid     (st_valid),
        .i_item      (st_item),
        .o_take      (take),
        .o_valid     (o_m_axis_tvalid),
        .i_ready     (i_m_axis_tready),
        .o_char      (o_m_axis_tdata),
        .o_eol       (o_m_axis_tuser),
        .o_last      (o_m_axis_tlast)
    );

endmodule

// ----- dv/testbench.sv -----
`timescale 1ns / 1ps

module testbench;
    import sla_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int SCRIPT_LEN  = 30;
    localparam int DUE_DEPTH   = 256;
    localparam logic [8*MARK_LEN-1:0] TRUNC_TAG = " ...[truncated]";

    typedef enum logic [1:0] {ROW_PRED, ROW_NONE, ROW_ONE, ROW_CFG} t_row_kind;

    typedef struct packed {
        t_row_kind         kind;
        logic [CFG_W-1:0]  limit;
        logic              action;
        logic [BYTE_W-1:0] value;
        logic [BYTE_W-1:0] ch;
        logic              eol;
    } t_row;

    typedef struct packed {
        logic [BYTE_W-1:0] ch;
        logic              eol;
        logic              last;
    } t_line_beat;

    logic              i_clk = 1'b0;
    logic              i_rst_n;
    logic              i_cfg_valid;
    logic              o_cfg_ready;
    logic [CFG_W-1:0]  i_cfg_data;
    logic              i_s_axis_tvalid;
    logic              o_s_axis_tready;
    logic [BYTE_W-1:0] i_s_axis_tdata;
    logic              i_s_axis_tuser;
    logic              o_m_axis_tvalid;
    logic              i_m_axis_tready;
    logic [BYTE_W-1:0] o_m_axis_tdata;
    logic              o_m_axis_tuser;
    logic              o_m_axis_tlast;

    // line framer model state
    logic [CFG_W-1:0]  limit_reg;
    int                cur_len;
    logic              cr_pending;
    logic              discarding;
    t_line_beat        produced [0:16];
    int                n_produced;

    // expected result beats, oldest first
    t_line_beat        due_mem [DUE_DEPTH];
    int                due_wr = 0;
    int                due_rd = 0;
    int                due_count = 0;
    t_line_beat        want;
    int                mismatches;
    int unsigned       cycle_count;
    int                gap_pct;
    int                stall_pct;

    // directed script: typed results where obvious, predictor elsewhere
    t_row script [SCRIPT_LEN] = '{
        '{ROW_ONE,  13'd0,    ACT_BYTE,  8'h41,    8'h41, 1'b0},
        '{ROW_NONE, 13'd0,    ACT_BYTE,  8'h00,    8'h00, 1'b0},
        '{ROW_NONE, 13'd0,    ACT_BYTE,  8'h1F,    8'h00, 1'b0},
        '{ROW_NONE, 13'd0,    ACT_BYTE,  CHAR_DEL, 8'h00, 1'b0},
        '{ROW_ONE,  13'd0,    ACT_BYTE,  8'h80,    8'h80, 1'b0},
        '{ROW_ONE,  13'd0,    ACT_BYTE,  8'hFF,    8'hFF, 1'b0},
        '{ROW_ONE,  13'd0,    ACT_BYTE,  8'h20,    8'h20, 1'b0},
        '{ROW_ONE,  13'd0,    ACT_BYTE,  CHAR_CR,  8'h00, 1'b1},
        // lf right after cr only closes the crlf pair
        '{ROW_NONE, 13'd0,    ACT_BYTE,  CHAR_LF,  8'h00, 1'b0},
        '{ROW_NONE, 13'd0,    ACT_BYTE,  CHAR_LF,  8'h00, 1'b0},
        '{ROW_NONE, 13'd0,    ACT_BYTE,  CHAR_CR,  8'h00, 1'b0},
        '{ROW_ONE,  13'd0,    ACT_BYTE,  8'h7E,    8'h7E, 1'b0},
        '{ROW_ONE,  13'd0,    ACT_BYTE,  CHAR_LF,  8'h00, 1'b1},
        '{ROW_ONE,  13'd0,    ACT_BYTE,  8'h5A,    8'h5A, 1'b0},
        '{ROW_ONE,  13'd0,    ACT_FLUSH, 8'hFF,    8'h00, 1'b1},
        '{ROW_NONE, 13'd0,    ACT_FLUSH, 8'h00,    8'h00, 1'b0},
        // zero limit behaves as one
        '{ROW_CFG,  13'd0,    ACT_BYTE,  8'h00,    8'h00, 1'b0},
        '{ROW_PRED, 13'd0,    ACT_BYTE,  8'h78,    8'h00, 1'b0},
        '{ROW_NONE, 13'd0,    ACT_BYTE,  8'h79,    8'h00, 1'b0},
        '{ROW_NONE, 13'd0,    ACT_BYTE,  CHAR_CR,  8'h00, 1'b0},
        '{ROW_CFG,  13'h1FFF, ACT_BYTE,  8'h00,    8'h00, 1'b0},
        '{ROW_ONE,  13'd0,    ACT_BYTE,  8'h71,    8'h71, 1'b0},
        '{ROW_ONE,  13'd0,    ACT_FLUSH, 8'h00,    8'h00, 1'b1},
        '{ROW_CFG,  13'd3,    ACT_BYTE,  8'h00,    8'h00, 1'b0},
        '{ROW_ONE,  13'd0,    ACT_BYTE,  8'h61,    8'h61, 1'b0},
        '{ROW_ONE,  13'd0,    ACT_BYTE,  8'h62,    8'h62, 1'b0},
        // limit drops below the open line
        '{ROW_CFG,  13'd2,    ACT_BYTE,  8'h00,    8'h00, 1'b0},
        '{ROW_PRED, 13'd0,    ACT_BYTE,  8'h63,    8'h00, 1'b0},
        '{ROW_NONE, 13'd0,    ACT_BYTE,  8'h64,    8'h00, 1'b0},
        '{ROW_NONE, 13'd0,    ACT_FLUSH, 8'h5A,    8'h00, 1'b0}
    };

    serial_line_assembler_core #(
        .LINE_LIMIT_MAX (LIMIT_MAX_DEF)
    ) dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_data      (i_cfg_data),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

    always #6 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
    end

    always @(negedge i_clk) begin
        i_m_axis_tready <= ($urandom_range(0, 99) >= stall_pct);
    end

    function automatic void due_put(input t_line_beat b);
        due_mem[due_wr] = b;
        due_wr = (due_wr + 1) % DUE_DEPTH;
        due_count++;
    endfunction

    function automatic t_line_beat due_get();
        t_line_beat b;
        b = due_mem[due_rd];
        due_rd = (due_rd + 1) % DUE_DEPTH;
        due_count--;
        return b;
    endfunction

    function automatic void emit(logic [BYTE_W-1:0] ch, logic eol);
        produced[n_produced] = '{ch, eol, 1'b0};
        n_produced++;
    endfunction

    function automatic void close_line();
        if (discarding) begin
            discarding = 1'b0;
        end else if (cur_len != 0) begin
            emit(8'h00, 1'b1);
        end
        cur_len = 0;
    endfunction

    // works out the result beats of one accepted input beat
    function automatic void frame_byte(logic act, logic [BYTE_W-1:0] b);
        int eff;
        eff = (limit_reg == 0) ? 1 : int'(limit_reg);
        if (eff > LIMIT_MAX_DEF) eff = LIMIT_MAX_DEF;
        n_produced = 0;
        if (act == ACT_FLUSH) begin
            close_line();
            cr_pending = 1'b0;
            discarding = 1'b0;
        end else if (b == CHAR_LF) begin
            if (cr_pending) cr_pending = 1'b0;
            else close_line();
        end else if (b == CHAR_CR) begin
            cr_pending = 1'b1;
            close_line();
        end else begin
            cr_pending = 1'b0;
            if (!discarding && b >= CHAR_SPACE && b != CHAR_DEL) begin
                emit(b, 1'b0);
                cur_len++;
                if (cur_len >= eff) begin
                    for (int i = 0; i < MARK_LEN; i++) begin
                        emit(TRUNC_TAG[8*(MARK_LEN-1-i) +: 8], 1'b0);
                    end
                    emit(8'h00, 1'b1);
                    cur_len = 0;
                    discarding = 1'b1;
                end
            end
        end
    endfunction

    task automatic wait_drained();
        i_s_axis_tvalid = 1'b0;
        while (due_count != 0) @(negedge i_clk);
    endtask

    task automatic send_item(input logic act, input logic [BYTE_W-1:0] val,
                             input t_row_kind kind, input logic [BYTE_W-1:0] t_ch,
                             input logic t_eol);
        logic taken;
        while ($urandom_range(0, 99) < gap_pct) begin
            i_s_axis_tvalid = 1'b0;
            @(negedge i_clk);
        end
        i_s_axis_tvalid = 1'b1;
        i_s_axis_tdata  = val;
        i_s_axis_tuser  = act;
        taken = 1'b0;
        while (!taken) begin
            @(posedge i_clk);
            taken = o_s_axis_tready;
            if (taken) begin
                frame_byte(act, val);
                if (kind == ROW_ONE) begin
                    due_put('{t_ch, t_eol, 1'b1});
                end else if (kind == ROW_PRED) begin
                    for (int k = 0; k < n_produced; k++) begin
                        due_put('{produced[k].ch, produced[k].eol, k == n_produced - 1});
                    end
                end
            end
            @(negedge i_clk);
        end
    endtask

    task automatic set_line_limit(input logic [CFG_W-1:0] v);
        wait_drained();
        // a dropped byte may still sit in the pipeline
        repeat (8) @(negedge i_clk);
        i_cfg_valid = 1'b1;
        i_cfg_data  = v;
        do @(posedge i_clk); while (!o_cfg_ready);
        limit_reg = v;
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    task automatic random_traffic(input int target);
        int sent;
        int lines;
        int lim;
        int len;
        int pick;
        logic [BYTE_W-1:0] b;
        lim = (limit_reg == 0) ? 1 : int'(limit_reg);
        if (lim > 30) lim = 30;
        sent  = 0;
        lines = 0;
        while (sent < target) begin
            pick = $urandom_range(0, 99);
            if (pick < 75) begin
                len = $urandom_range(0, lim + 2);
                for (int k = 0; k < len; k++) begin
                    if ($urandom_range(0, 9) == 0) begin
                        b = ($urandom_range(0, 3) == 0) ? CHAR_DEL : 8'($urandom_range(0, 31));
                        send_item(ACT_BYTE, b, ROW_PRED, 8'h00, 1'b0);
                        sent++;
                    end else begin
                        b = ($urandom_range(0, 4) == 0) ? 8'($urandom_range(128, 255))
                                                       : 8'($urandom_range(32, 126));
                        send_item(ACT_BYTE, b, ROW_PRED, 8'h00, 1'b0);
                        sent++;
                    end
                end
                case ($urandom_range(0, 3))
                    0: send_item(ACT_BYTE, CHAR_CR, ROW_PRED, 8'h00, 1'b0);
                    1: send_item(ACT_BYTE, CHAR_LF, ROW_PRED, 8'h00, 1'b0);
                    2: begin
                        send_item(ACT_BYTE, CHAR_CR, ROW_PRED, 8'h00, 1'b0);
                        send_item(ACT_BYTE, CHAR_LF, ROW_PRED, 8'h00, 1'b0);
                    end
                    default: send_item(ACT_FLUSH, 8'($urandom_range(0, 255)), ROW_PRED,
                                       8'h00, 1'b0);
                endcase
                sent++;
                lines++;
                if (lines == 3 || $urandom_range(0, 39) == 0) wait_drained();
            end else if (pick < 92) begin
                send_item(ACT_BYTE, 8'($urandom_range(0, 255)), ROW_PRED, 8'h00, 1'b0);
                sent++;
            end else begin
                send_item(ACT_FLUSH, 8'($urandom_range(0, 255)), ROW_PRED, 8'h00, 1'b0);
                sent++;
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            if (due_count == 0) begin
                $error("result beat with nothing expected: tdata %h tuser %b tlast %b",
                       o_m_axis_tdata, o_m_axis_tuser, o_m_axis_tlast);
                mismatches++;
            end else begin
                want = due_get();
                if (o_m_axis_tdata !== want.ch) begin
                    $error("char_value: expected %h, actual %h", want.ch, o_m_axis_tdata);
                    mismatches++;
                end
                if (o_m_axis_tuser !== want.eol) begin
                    $error("end_of_line: expected %b, actual %b", want.eol, o_m_axis_tuser);
                    mismatches++;
                end
                if (o_m_axis_tlast !== want.last) begin
                    $error("last: expected %b, actual %b", want.last, o_m_axis_tlast);
                    mismatches++;
                end
            end
        end
    end

    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("simulation failed");
        $finish;
    end

    initial begin
        cycle_count     = 0;
        mismatches      = 0;
        gap_pct         = 0;
        stall_pct       = 0;
        i_rst_n         = 1'b0;
        i_cfg_valid     = 1'b0;
        i_cfg_data      = '0;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tdata  = '0;
        i_s_axis_tuser  = ACT_BYTE;
        i_m_axis_tready = 1'b0;
        limit_reg       = MAX_LINE_RESET;
        cur_len         = 0;
        cr_pending      = 1'b0;
        discarding      = 1'b0;
        repeat (9) @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (script[r]) begin
            if (script[r].kind == ROW_CFG) begin
                set_line_limit(script[r].limit);
            end else begin
                send_item(script[r].action, script[r].value, script[r].kind,
                          script[r].ch, script[r].eol);
            end
        end

        for (int p = 0; p < 4; p++) begin
            case (p)
                0: begin gap_pct = 0;  stall_pct = 0;  set_line_limit(13'd6);  end
                1: begin gap_pct = 66; stall_pct = 0;  set_line_limit(13'd1);  end
                2: begin gap_pct = 0;  stall_pct = 66; set_line_limit(13'd13); end
                default: begin
                    gap_pct   = 12;
                    stall_pct = 12;
                    set_line_limit(13'($urandom_range(2, 24)));
                end
            endcase
            random_traffic(40);
        end

        wait_drained();
        repeat (10) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

// ----- serial_line_assembler_core.f -----
rtl/core/sla_pkg.sv
rtl/core/sla_in_stage.sv
rtl/core/sla_framer.sv
rtl/core/serial_line_assembler_core.sv
dv/testbench.sv
